[hdl/two_stack_cursor_list_defines.svh]
// Assertion macros shared by the cursor list modules.
`ifndef TWO_STACK_CURSOR_LIST_DEFINES_SVH
`define TWO_STACK_CURSOR_LIST_DEFINES_SVH

// Invariant that holds at every clock edge outside reset.
`define TSCL_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define TSCL_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TSCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tscl_pkg.sv]
// Types, codes and widths shared by the cursor list modules.
package tscl_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int CMD_W    = 3;
  localparam int VAL_W    = 16;
  localparam int SIZE_W   = 7;
  localparam int S_USER_W = 3;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 40;
  localparam int M_PAD_W  = M_DATA_W - (VAL_W + 1 + 1 + SIZE_W + SIZE_W + 1);

  // Command codes carried in the input transaction
  localparam logic [CMD_W-1:0] CMD_INSERT      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SHIFT_LEFT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SHIFT_RIGHT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE      = 3'd3;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_FIN
  } state_t;

  // Resolved operation, after checking the stack counts
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_REJECT,
    OP_SHL,
    OP_SHR,
    OP_POP,
    OP_CLEAR,
    OP_REFILL
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic lp_zero;
    logic rp_zero;
    logic rp_one;
    logic full;
  } dp_stat_t;

endpackage

[hdl/tscl_ctrl.sv]
// Controller: handshakes, command decode and sequencing of one item.
`include "two_stack_cursor_list_defines.svh"

module tscl_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [tscl_pkg::CMD_W-1:0]      command,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  tscl_pkg::dp_stat_t              stat,
  output tscl_pkg::dp_cmd_t               cmd
);
  import tscl_pkg::*;

  state_t state;
  state_t state_next;
  logic   m_tvalid_next;
  logic   out_free;
  op_t    op_dec;

  assign out_free = !m_tvalid || m_tready;

  // Resolve the command against the current stack counts
  always_comb begin
    case (command)
      CMD_INSERT: begin
        op_dec = stat.full ? OP_REJECT : OP_INSERT;
      end
      CMD_SHIFT_LEFT: begin
        op_dec = stat.rp_zero ? OP_NONE : OP_SHL;
      end
      CMD_SHIFT_RIGHT: begin
        op_dec = stat.lp_zero ? OP_NONE : OP_SHR;
      end
      CMD_DELETE: begin
        if (stat.rp_zero || stat.rp_one) begin
          if (!stat.lp_zero) begin
            op_dec = OP_REFILL;
          end else begin
            op_dec = stat.rp_one ? OP_CLEAR : OP_NONE;
          end
        end else begin
          op_dec = OP_POP;
        end
      end
      default: begin
        op_dec = OP_NONE;
      end
    endcase
  end

  // Next state
  always_comb begin
    case (state)
      ST_IDLE: begin
        state_next = s_tvalid ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        state_next = out_free ? ST_IDLE : ST_FIN;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    s_tready   = 1'b0;
    cmd.start  = 1'b0;
    cmd.op     = op_dec;
    cmd.finish = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        cmd.start = s_tvalid;
      end
      ST_FIN: begin
        cmd.finish = out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // Hold the result valid until the downstream side takes it
  always_comb begin
    if (cmd.finish) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  `TSCL_ASSERT_NEXT(a_accept_enters_fin, s_tvalid && s_tready, state == ST_FIN, "accept did not enter finish")
  `TSCL_ASSERT_NEXT(a_finish_sets_valid, cmd.finish, m_tvalid, "finished result not presented")
  `TSCL_ASSERT_IMPLIES(a_no_start_in_fin, state == ST_FIN, !cmd.start && !s_tready, "start while item in flight")

endmodule

[hdl/tscl_dpath.sv]
// Datapath: stack memories, counts, cached top and result register.
`include "two_stack_cursor_list_defines.svh"

module tscl_dpath #(
  parameter int DEPTH = tscl_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [tscl_pkg::VAL_W-1:0]      car_value,
  input  tscl_pkg::dp_cmd_t               cmd,
  output tscl_pkg::dp_stat_t              stat,
  output logic [tscl_pkg::M_DATA_W-1:0]   m_tdata
);
  import tscl_pkg::*;

  localparam int PW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PW:0] DEPTH_T = (PW + 1)'(DEPTH);

  logic [VAL_W-1:0] lmem [DEPTH];
  logic [VAL_W-1:0] rmem [DEPTH];

  logic [PW-1:0]    lp, lp_next;
  logic [PW-1:0]    rp, rp_next;
  logic [VAL_W-1:0] top, top_next;
  op_t              pend_op;

  logic [PW-1:0]    lp_m1, rp_m1, rp_m2;
  logic [PW:0]      total;

  logic             l_we, l_re, r_we, r_re;
  logic [AW-1:0]    l_waddr, l_raddr, r_waddr, r_raddr;
  logic [VAL_W-1:0] l_wdata, r_wdata;
  logic [VAL_W-1:0] l_rdata, r_rdata;

  logic [PW+SIZE_W-1:0] lp_ext, rp_ext;

  logic [VAL_W-1:0]  out_value;
  logic              out_present;
  logic              out_empty;
  logic [SIZE_W-1:0] out_left;
  logic [SIZE_W-1:0] out_right;
  logic              out_rejected;

  assign lp_m1 = lp - PW'(1);
  assign rp_m1 = rp - PW'(1);
  assign rp_m2 = rp - PW'(2);
  assign total = {1'b0, lp} + {1'b0, rp};

  // Report counts to the controller
  assign stat.lp_zero = (lp == '0);
  assign stat.rp_zero = (rp == '0);
  assign stat.rp_one  = (rp == PW'(1));
  assign stat.full    = (total >= DEPTH_T);

  // Pointer moves and memory ports for the start and finish cycles
  always_comb begin
    lp_next  = lp;
    rp_next  = rp;
    top_next = top;
    l_we     = 1'b0;
    l_re     = 1'b0;
    r_we     = 1'b0;
    r_re     = 1'b0;
    l_waddr  = lp[AW-1:0];
    l_wdata  = top;
    l_raddr  = lp_m1[AW-1:0];
    r_waddr  = rp[AW-1:0];
    r_wdata  = car_value;
    r_raddr  = rp_m2[AW-1:0];
    if (cmd.start) begin
      case (cmd.op)
        OP_INSERT: begin
          r_we     = 1'b1;
          rp_next  = rp + PW'(1);
          top_next = car_value;
        end
        OP_SHL: begin
          l_we    = 1'b1;
          r_re    = 1'b1;
          lp_next = lp + PW'(1);
          rp_next = rp_m1;
        end
        OP_SHR: begin
          l_re    = 1'b1;
          lp_next = lp_m1;
          rp_next = rp + PW'(1);
        end
        OP_POP: begin
          r_re    = 1'b1;
          rp_next = rp_m1;
        end
        OP_CLEAR: begin
          rp_next = '0;
        end
        OP_REFILL: begin
          l_re    = 1'b1;
          lp_next = lp_m1;
          rp_next = PW'(1);
        end
        default: begin
          rp_next = rp;
        end
      endcase
    end
    if (cmd.finish) begin
      case (pend_op)
        OP_SHL, OP_POP: begin
          top_next = r_rdata;
        end
        OP_SHR, OP_REFILL: begin
          // Land the element pulled from the left stack on the right top
          r_we     = 1'b1;
          r_waddr  = rp_m1[AW-1:0];
          r_wdata  = l_rdata;
          top_next = l_rdata;
        end
        default: begin
          top_next = top;
        end
      endcase
    end
  end

  // Left stack memory
  always_ff @(posedge clk) begin
    if (l_we) begin
      lmem[l_waddr] <= l_wdata;
    end
    if (l_re) begin
      l_rdata <= lmem[l_raddr];
    end
  end

  // Right stack memory
  always_ff @(posedge clk) begin
    if (r_we) begin
      rmem[r_waddr] <= r_wdata;
    end
    if (r_re) begin
      r_rdata <= rmem[r_raddr];
    end
  end

  // Counts and pending operation
  always_ff @(posedge clk) begin
    if (rst) begin
      lp      <= '0;
      rp      <= '0;
      pend_op <= OP_NONE;
    end else begin
      lp <= lp_next;
      rp <= rp_next;
      if (cmd.start) begin
        pend_op <= cmd.op;
      end
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
  end

  assign lp_ext = {{SIZE_W{1'b0}}, lp};
  assign rp_ext = {{SIZE_W{1'b0}}, rp};

  // Capture the result once the item is done
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_value    <= (rp != '0) ? top_next : '0;
      out_present  <= (rp != '0);
      out_empty    <= (lp == '0) && (rp == '0);
      out_left     <= lp_ext[SIZE_W-1:0];
      out_right    <= rp_ext[SIZE_W-1:0];
      out_rejected <= (pend_op == OP_REJECT);
    end
  end

  assign m_tdata = {{M_PAD_W{1'b0}}, out_rejected, out_right, out_left,
                    out_empty, out_present, out_value};

  `TSCL_ASSERT_ALWAYS(a_total_bounded, total <= DEPTH_T, "element count exceeds depth")
  `TSCL_ASSERT_NEXT(a_insert_grows, cmd.start && (cmd.op == OP_INSERT), rp == $past(rp) + PW'(1), "insert did not push")
  `TSCL_ASSERT_NEXT(a_present_tracks, cmd.finish, out_present == (rp != '0), "present flag disagrees with count")

endmodule

[hdl/two_stack_cursor_list.sv]
// Top level of the two-stack cursor list.
//
// Input channel s_*: one transaction per command. s_tuser carries the command
// (insert, shift left, shift right, delete, observe) and s_tdata the value
// to insert. Output channel m_*: one result transaction per command with the
// active value, present and empty flags, both stack sizes and the reject flag.
// Each command runs through an accept cycle and then a finish cycle: the accept
// cycle resolves the command, moves the counts and issues at most one stack
// memory read; the finish cycle takes the registered read data, writes an
// element moved from the left stack to the right stack and loads the result
// register. The single registered read port per stack sets this order: the
// block takes no new command before the last one has finished. A new command
// is taken while the previous result still waits in the output register; if
// the receiver holds m_tready low, the next item stops in its finish cycle
// until the register frees.
// Reset clears both counts and the handshake state; the stack memories are
// not cleared, as no entry is read before it is written.
module two_stack_cursor_list #(
  parameter int DEPTH = tscl_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [tscl_pkg::S_DATA_W-1:0]      s_tdata,  // [15:0] car_value
  input  logic [tscl_pkg::S_USER_W-1:0]      s_tuser,  // [2:0] command
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [15:0] active_value, [16] active_present, [17] list_empty,
  // [24:18] left_size, [31:25] right_size, [32] rejected, [39:33] zero
  output logic [tscl_pkg::M_DATA_W-1:0]      m_tdata
);
  import tscl_pkg::*;

  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  tscl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .command  (s_tuser[CMD_W-1:0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (dstat),
    .cmd      (dcmd)
  );

  tscl_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .car_value (s_tdata[VAL_W-1:0]),
    .cmd       (dcmd),
    .stat      (dstat),
    .m_tdata   (m_tdata)
  );

endmodule

[tb/sv/tb_two_stack_cursor_list.sv]
// Self-checking testbench for the two-stack cursor list: directed and random commands.
module tb_two_stack_cursor_list;
  timeunit 1ns;
  timeprecision 1ps;

  import tscl_pkg::*;

  localparam int LIST_DEPTH  = DEPTH_DEF;
  localparam int RAND_ITEMS  = 700;
  localparam int QUIET_ITEMS = 100;
  localparam int DRAIN_WAIT  = 20;

  // Codes that the package leaves unnamed
  localparam logic [CMD_W-1:0] CMD_OBSERVE    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SPARE_LOW  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID  = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HIGH = 3'd7;

  // Bit positions of the result fields in m_tdata
  localparam int POS_PRESENT = VAL_W;
  localparam int POS_EMPTY   = VAL_W + 1;
  localparam int POS_LEFT    = VAL_W + 2;
  localparam int POS_RIGHT   = VAL_W + 2 + SIZE_W;
  localparam int POS_REJECT  = VAL_W + 2 + 2 * SIZE_W;

  typedef struct packed {
    logic [VAL_W-1:0]  active_value;
    logic              active_present;
    logic              list_empty;
    logic [SIZE_W-1:0] left_size;
    logic [SIZE_W-1:0] right_size;
    logic              rejected;
  } cursor_view_t;

  // Command mix of one stretch of random stimulus
  typedef enum int {
    MIX_FILL,
    MIX_SHIFT_LEFT,
    MIX_SHIFT_RIGHT,
    MIX_DRAIN,
    MIX_ANY
  } cmd_mix_t;

  // Shadow of the two stacks and the queue of views they should produce
  class cursor_scoreboard;
    logic [VAL_W-1:0] left_stk [LIST_DEPTH];
    logic [VAL_W-1:0] right_stk[LIST_DEPTH];
    int               left_cnt;
    int               right_cnt;
    cursor_view_t     views_due[$];
    int               errors;

    function new();
      left_cnt  = 0;
      right_cnt = 0;
      errors    = 0;
    endfunction

    function int pending();
      return views_due.size();
    endfunction

    task report(input string what);
      errors++;
      $display("%0t mismatch: %s", $realtime, what);
    endtask

    function void pull_from_left();
      if (left_cnt > 0 && right_cnt < LIST_DEPTH) begin
        left_cnt--;
        right_stk[right_cnt] = left_stk[left_cnt];
        right_cnt++;
      end
    endfunction

    function void push_to_left();
      if (right_cnt > 0 && left_cnt < LIST_DEPTH) begin
        right_cnt--;
        left_stk[left_cnt] = right_stk[right_cnt];
        left_cnt++;
      end
    endfunction

    // Apply one accepted command and queue the view it leaves behind
    function void note_input(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val);
      cursor_view_t v;
      v = '0;
      case (cmd)
        CMD_INSERT: begin
          if (left_cnt + right_cnt >= LIST_DEPTH) begin
            v.rejected = 1'b1;
          end else begin
            right_stk[right_cnt] = val;
            right_cnt++;
          end
        end
        CMD_SHIFT_LEFT:  push_to_left();
        CMD_SHIFT_RIGHT: pull_from_left();
        CMD_DELETE: begin
          if (right_cnt > 0) right_cnt--;
          if (right_cnt == 0) pull_from_left();
        end
        default: ;
      endcase
      if (right_cnt > 0) begin
        v.active_value   = right_stk[right_cnt-1];
        v.active_present = 1'b1;
      end
      v.list_empty = (left_cnt == 0 && right_cnt == 0);
      v.left_size  = left_cnt[SIZE_W-1:0];
      v.right_size = right_cnt[SIZE_W-1:0];
      views_due.push_back(v);
    endfunction

    // Compare one result transaction with the oldest queued view
    task check_result(input logic [M_DATA_W-1:0] data);
      cursor_view_t exp_v;
      if (views_due.size() == 0) begin
        report($sformatf("result %h with nothing outstanding", data));
      end else begin
        exp_v = views_due.pop_front();
        if (data[VAL_W-1:0] !== exp_v.active_value)
          report($sformatf("active_value %h, want %h", data[VAL_W-1:0], exp_v.active_value));
        if (data[POS_PRESENT] !== exp_v.active_present)
          report($sformatf("active_present %b, want %b", data[POS_PRESENT],
                           exp_v.active_present));
        if (data[POS_EMPTY] !== exp_v.list_empty)
          report($sformatf("list_empty %b, want %b", data[POS_EMPTY], exp_v.list_empty));
        if (data[POS_LEFT +: SIZE_W] !== exp_v.left_size)
          report($sformatf("left_size %0d, want %0d", data[POS_LEFT +: SIZE_W],
                           exp_v.left_size));
        if (data[POS_RIGHT +: SIZE_W] !== exp_v.right_size)
          report($sformatf("right_size %0d, want %0d", data[POS_RIGHT +: SIZE_W],
                           exp_v.right_size));
        if (data[POS_REJECT] !== exp_v.rejected)
          report($sformatf("rejected %b, want %b", data[POS_REJECT], exp_v.rejected));
      end
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic [S_USER_W-1:0] s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;

  cursor_scoreboard book;
  bit               quiet;

  two_stack_cursor_list #(.DEPTH(LIST_DEPTH)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2000000;
    $display("tb_two_stack_cursor_list: done, errors");
    $finish;
  end

  // Receiver: alternate ready stretches with stall bursts, always ready near the end
  initial begin
    int stall_left;
    int ready_left;
    stall_left = 0;
    ready_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (ready_left > 0) begin
        ready_left--;
        m_tready <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        m_tready <= 1'b0;
      end else begin
        ready_left = $urandom_range(1, 24) - 1;
        m_tready <= 1'b1;
      end
    end
  end

  // Check every result transaction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) book.check_result(m_tdata);
  end

  // Present one command, with an occasional idle burst ahead of it
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.note_input(cmd, val);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Draw a command weighted by the current mix
  function automatic logic [CMD_W-1:0] pick_cmd(input cmd_mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:        if (roll < 85) return CMD_INSERT;
      MIX_SHIFT_LEFT:  if (roll < 75) return CMD_SHIFT_LEFT;
      MIX_SHIFT_RIGHT: if (roll < 75) return CMD_SHIFT_RIGHT;
      MIX_DRAIN:       if (roll < 75) return CMD_DELETE;
      default:         ;
    endcase
    return CMD_W'($urandom_range(0, 7));
  endfunction

  initial begin
    cmd_mix_t mix;
    int       seg_left;
    int       seg_no;
    book     = new();
    quiet    = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty list, extremes of the value, moves across the cursor
    send_cmd(CMD_OBSERVE,     16'h0000);
    send_cmd(CMD_DELETE,      16'hFFFF);
    send_cmd(CMD_SHIFT_LEFT,  16'h1234);
    send_cmd(CMD_SHIFT_RIGHT, 16'hFFFF);
    send_cmd(CMD_INSERT,      16'h0000);
    send_cmd(CMD_INSERT,      16'hFFFF);
    send_cmd(CMD_INSERT,      16'h8001);
    send_cmd(CMD_SHIFT_LEFT,  16'hFFFF);
    send_cmd(CMD_SHIFT_LEFT,  16'h0000);
    send_cmd(CMD_SHIFT_LEFT,  16'h5A5A);
    // shift left with nothing at the cursor
    send_cmd(CMD_SHIFT_LEFT,  16'hA5A5);
    // delete with an empty right stack refills from the left
    send_cmd(CMD_DELETE,      16'h0000);
    // delete of the single right element, refilled from the left
    send_cmd(CMD_DELETE,      16'hFFFF);
    send_cmd(CMD_SHIFT_RIGHT, 16'h0001);
    // shift right with nothing on the left
    send_cmd(CMD_SHIFT_RIGHT, 16'h7FFF);
    // unused codes behave as observe
    send_cmd(CMD_SPARE_LOW,   16'hFFFF);
    send_cmd(CMD_SPARE_MID,   16'h0000);
    send_cmd(CMD_SPARE_HIGH,  16'hFFFF);
    send_cmd(CMD_OBSERVE,     16'hFFFF);
    send_cmd(CMD_DELETE,      16'h0000);
    send_cmd(CMD_DELETE,      16'h0000);
    send_cmd(CMD_OBSERVE,     16'h0000);

    // Random: stretches of one command mix; the first few walk the extremes
    seg_left = 0;
    seg_no   = 0;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (seg_left == 0) begin
        case (seg_no)
          0:       mix = MIX_FILL;
          1:       mix = MIX_SHIFT_LEFT;
          2:       mix = MIX_SHIFT_RIGHT;
          3:       mix = MIX_DRAIN;
          default: mix = cmd_mix_t'($urandom_range(0, 4));
        endcase
        seg_left = (seg_no == 0) ? 100 : $urandom_range(30, 90);
        seg_no++;
      end
      seg_left--;
      if (i >= RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      send_cmd(pick_cmd(mix), pick_value());
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (book.errors == 0) begin
      $display("tb_two_stack_cursor_list: done, clean");
    end else begin
      $display("tb_two_stack_cursor_list: done, errors");
    end
    $finish;
  end

endmodule

[two_stack_cursor_list.f]
+incdir+hdl
hdl/tscl_pkg.sv
hdl/tscl_ctrl.sv
hdl/tscl_dpath.sv
hdl/two_stack_cursor_list.sv
tb/sv/tb_two_stack_cursor_list.sv
